// File: rtl/mbet_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbet_pkg: shared types and constants for the Mandelbrot escape-time pixel unit
// Payload structs, configuration register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package mbet_pkg;

    localparam int PIX_BITS       = 13;
    localparam int ORIGIN_BITS    = 32;
    localparam int STEP_BITS      = 29;
    localparam int COUNT_BITS     = 12;
    localparam int GRAY_BITS      = 8;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 32;

    // multiplier digit, one digit of the second operand per cycle
    localparam int MUL_DIGIT_BITS = 16;

    // gray level search: (2g-1)^2 * max_iter <= 260100 * t
    localparam int GRAY_SQ_BITS   = 18;
    localparam int GRAY_PROD_BITS = 30;
    localparam int GRAY_STEP_BITS = 3;
    localparam logic [GRAY_SQ_BITS-1:0] GRAY_SCALE_SQ4 = 18'd260100;

    localparam logic [ORIGIN_BITS-1:0] RST_ORIGIN_RE = -32'sd563714457;
    localparam logic [ORIGIN_BITS-1:0] RST_ORIGIN_IM = -32'sd322122547;
    localparam logic [STEP_BITS-1:0]   RST_STEP_RE   = 29'd134218;
    localparam logic [STEP_BITS-1:0]   RST_STEP_IM   = 29'd134218;
    localparam logic [COUNT_BITS-1:0]  RST_MAX_ITER  = 12'd500;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ORIGIN_RE = 3'd0,
        CFG_ORIGIN_IM = 3'd1,
        CFG_STEP_RE   = 3'd2,
        CFG_STEP_IM   = 3'd3,
        CFG_MAX_ITER  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [PIX_BITS-1:0] pixel_row;
        logic [PIX_BITS-1:0] pixel_col;
    } mbet_in_t;

    typedef struct packed {
        logic [GRAY_BITS-1:0]  gray;
        logic [COUNT_BITS-1:0] escape_count;
        logic                  inside_set;
    } mbet_out_t;

endpackage
`default_nettype wire

// File: rtl/mbet_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbet_mul: shared iterative unsigned multiplier
// Multiplies two OP_BITS operands exactly, one 16-bit digit of op_b per cycle,
// most significant digit first, with a shift-and-add accumulator.
// ----------------------------------------------------------------------------
module mbet_mul #(
    parameter int OP_BITS = 44
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [OP_BITS-1:0]     op_a,
    input  wire logic [OP_BITS-1:0]     op_b,
    output logic                        busy,
    output logic                        done,
    output logic [2*OP_BITS-1:0]        product
);
    import mbet_pkg::*;

    localparam int NDIG = (OP_BITS + MUL_DIGIT_BITS - 1) / MUL_DIGIT_BITS;
    localparam int BB   = NDIG * MUL_DIGIT_BITS;
    localparam int PB   = 2 * OP_BITS;
    localparam int CNTB = $clog2(NDIG + 1);
    localparam logic [CNTB-1:0] NDIG_CNT = CNTB'(NDIG);

    logic [OP_BITS-1:0]                a_reg;
    logic [BB-1:0]                     b_reg;
    logic [PB-1:0]                     acc_reg;
    logic [PB-1:0]                     acc_next;
    logic [CNTB-1:0]                   cnt_reg;
    logic                              busy_reg;
    logic                              done_reg;
    logic [MUL_DIGIT_BITS-1:0]         digit;
    logic [OP_BITS+MUL_DIGIT_BITS-1:0] part;

    assign digit    = b_reg[BB-1 -: MUL_DIGIT_BITS];
    assign part     = a_reg * digit;
    assign acc_next = (acc_reg << MUL_DIGIT_BITS) + PB'(part);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= NDIG_CNT;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNTB'(1);
                if (cnt_reg == CNTB'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= op_a;
            b_reg   <= BB'(op_b);
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            b_reg   <= b_reg << MUL_DIGIT_BITS;
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = acc_reg;

endmodule
`default_nettype wire

// File: rtl/mbet_gray.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbet_gray: escape count to gray level
// Bitwise search for the largest g with (2g-1)^2 * limit <= 260100 * count;
// for each bit, square the odd candidate, then scale and compare.
// ----------------------------------------------------------------------------
module mbet_gray (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               start,
    input  wire logic [mbet_pkg::COUNT_BITS-1:0]    count,
    input  wire logic [mbet_pkg::COUNT_BITS-1:0]    limit,
    output logic                                    done,
    output logic [mbet_pkg::GRAY_BITS-1:0]          gray
);
    import mbet_pkg::*;

    logic [GRAY_PROD_BITS-1:0] rhs_reg;
    logic [GRAY_PROD_BITS-1:0] lhs;
    logic [GRAY_SQ_BITS-1:0]   sq_reg;
    logic [GRAY_BITS-1:0]      g_reg;
    logic [GRAY_BITS-1:0]      cand;
    logic [GRAY_BITS:0]        odd;
    logic [GRAY_STEP_BITS-1:0] bit_reg;
    logic                      phase_reg;
    logic                      busy_reg;
    logic                      done_reg;

    assign cand = g_reg | (GRAY_BITS'(1) << bit_reg);
    assign odd  = {cand, 1'b0} - (GRAY_BITS+1)'(1);
    assign lhs  = sq_reg * limit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            bit_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
                bit_reg   <= '1;
            end else if (busy_reg) begin
                phase_reg <= !phase_reg;
                if (phase_reg) begin
                    if (bit_reg == '0) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end else begin
                        bit_reg <= bit_reg - GRAY_STEP_BITS'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rhs_reg <= GRAY_SCALE_SQ4 * count;
            g_reg   <= '0;
        end else if (busy_reg) begin
            if (!phase_reg) begin
                sq_reg <= odd * odd;
            end else if (lhs <= rhs_reg) begin
                g_reg <= cand;
            end
        end
    end

    assign done = done_reg;
    assign gray = g_reg;

endmodule
`default_nettype wire

// File: rtl/mandelbrot_escape_time_pixel_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_top: Mandelbrot escape-time pixel unit
// Maps a pixel to c = origin + (col*step_re, row*step_im) in signed fixed
// point with FRAC_BITS fraction bits, iterates z <- z*z + c from z = c and
// reports the escape count, an inside flag and a gray level.
// ----------------------------------------------------------------------------
// One pixel is in flight at a time; s_ready is high only while the unit is
// idle, and a finished result waits in the output register so the next pixel
// can be taken before it is read. Every iteration runs three exact products
// (re*re, im*im, re*im) through one shared multiplier that consumes a 16-bit
// digit per cycle, with D = ceil((ZW-1)/16) digits per operand (D = 3 at the
// default widths). A pixel begins with setup, its final escape test runs only
// the two squarings, and an 8-step gray-level search follows; points inside
// the set skip the search. The user must see that registers are written
// through the cfg port only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_top #(
    parameter int COORD_BITS = 13,
    parameter int FRAC_BITS  = 28
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire mbet_pkg::mbet_in_t                     s_data,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output mbet_pkg::mbet_out_t                         m_data,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [mbet_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  wire logic [mbet_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);
    import mbet_pkg::*;

    // coordinate bits actually used, and widths that bound every z value
    localparam int USE_BITS = (COORD_BITS < PIX_BITS) ? COORD_BITS : PIX_BITS;
    localparam int CPW      = USE_BITS + STEP_BITS;
    localparam int CB       = ((CPW > ORIGIN_BITS - 1) ? CPW : ORIGIN_BITS - 1) + 1;
    localparam int ZW       = ((FRAC_BITS + 2 > CB) ? FRAC_BITS + 2 : CB) + 2;
    localparam int MW       = ZW - 1;
    localparam int PB       = 2 * MW;
    localparam logic [PB:0] ESC_LIMIT = (PB + 1)'(1) << (2 * FRAC_BITS + 2);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_INIT  = 10'b00_0000_0010,
        S_CHECK = 10'b00_0000_0100,
        S_SQRE  = 10'b00_0000_1000,
        S_SQIM  = 10'b00_0001_0000,
        S_TEST  = 10'b00_0010_0000,
        S_CROSS = 10'b00_0100_0000,
        S_UPD   = 10'b00_1000_0000,
        S_GRAY  = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [ORIGIN_BITS-1:0] origin_re_reg, origin_im_reg;
    logic [STEP_BITS-1:0]   step_re_reg, step_im_reg;
    logic [COUNT_BITS-1:0]  max_iter_reg;

    logic [CPW-1:0]         prod_re_reg, prod_im_reg;
    logic [ZW-1:0]          c_re_reg, c_im_reg, z_re_reg, z_im_reg;
    logic [ZW-1:0]          c_re_calc, c_im_calc, nre, nim;
    logic [ZW-1:0]          neg_re, neg_im;
    logic [MW-1:0]          mag_re, mag_im;
    logic [PB-1:0]          sq_re_reg, sq_im_reg, cross_reg;
    logic [PB:0]            sq_sum;
    logic                   escape;
    logic [COUNT_BITS-1:0]  t_reg;
    logic                   in_set;

    logic signed [PB:0]     diff_sq, diff_shr;
    logic signed [PB+1:0]   cross2, cross_sgn, cross_shr;

    logic                   mul_start, mul_busy, mul_done;
    logic [MW-1:0]          mul_a, mul_b;
    logic [PB-1:0]          mul_prod;

    logic                   gray_start, gray_done;
    logic [GRAY_BITS-1:0]   gray_val;

    logic                   out_load;
    logic                   m_valid_reg;
    mbet_out_t              out_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_re_reg <= RST_ORIGIN_RE;
            origin_im_reg <= RST_ORIGIN_IM;
            step_re_reg   <= RST_STEP_RE;
            step_im_reg   <= RST_STEP_IM;
            max_iter_reg  <= RST_MAX_ITER;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ORIGIN_RE: origin_re_reg <= cfg_wdata[ORIGIN_BITS-1:0];
                CFG_ORIGIN_IM: origin_im_reg <= cfg_wdata[ORIGIN_BITS-1:0];
                CFG_STEP_RE:   step_re_reg   <= cfg_wdata[STEP_BITS-1:0];
                CFG_STEP_IM:   step_im_reg   <= cfg_wdata[STEP_BITS-1:0];
                CFG_MAX_ITER:  max_iter_reg  <= cfg_wdata[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // datapath arithmetic
    assign c_re_calc = {{(ZW-ORIGIN_BITS){origin_re_reg[ORIGIN_BITS-1]}}, origin_re_reg}
                     + {{(ZW-CPW){1'b0}}, prod_re_reg};
    assign c_im_calc = {{(ZW-ORIGIN_BITS){origin_im_reg[ORIGIN_BITS-1]}}, origin_im_reg}
                     + {{(ZW-CPW){1'b0}}, prod_im_reg};

    assign neg_re = -z_re_reg;
    assign neg_im = -z_im_reg;
    assign mag_re = z_re_reg[ZW-1] ? neg_re[MW-1:0] : z_re_reg[MW-1:0];
    assign mag_im = z_im_reg[ZW-1] ? neg_im[MW-1:0] : z_im_reg[MW-1:0];

    assign sq_sum = {1'b0, sq_re_reg} + {1'b0, sq_im_reg};
    assign escape = sq_sum > ESC_LIMIT;

    // square difference and doubled cross product floored to FRAC_BITS fraction bits before c is added
    assign diff_sq   = $signed({1'b0, sq_re_reg}) - $signed({1'b0, sq_im_reg});
    assign diff_shr  = diff_sq >>> FRAC_BITS;
    assign cross2    = $signed({1'b0, cross_reg, 1'b0});
    assign cross_sgn = (z_re_reg[ZW-1] ^ z_im_reg[ZW-1]) ? -cross2 : cross2;
    assign cross_shr = cross_sgn >>> FRAC_BITS;
    assign nre       = diff_shr[ZW-1:0] + c_re_reg;
    assign nim       = cross_shr[ZW-1:0] + c_im_reg;

    assign in_set = (t_reg == max_iter_reg);

    // sequencer
    always_comb begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_a      = mag_re;
        mul_b      = mag_re;
        gray_start = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_INIT;
            end
            S_INIT: state_next = S_CHECK;
            S_CHECK: begin
                if (in_set) begin
                    state_next = S_DONE;
                end else begin
                    mul_start  = 1'b1;
                    state_next = S_SQRE;
                end
            end
            S_SQRE: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_a      = mag_im;
                    mul_b      = mag_im;
                    state_next = S_SQIM;
                end
            end
            S_SQIM: begin
                if (mul_done) state_next = S_TEST;
            end
            S_TEST: begin
                if (escape) begin
                    gray_start = 1'b1;
                    state_next = S_GRAY;
                end else begin
                    mul_start  = 1'b1;
                    mul_b      = mag_im;
                    state_next = S_CROSS;
                end
            end
            S_CROSS: begin
                if (mul_done) state_next = S_UPD;
            end
            S_UPD: state_next = S_CHECK;
            S_GRAY: begin
                if (gray_done) state_next = S_DONE;
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            t_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == S_INIT) begin
                t_reg <= '0;
            end else if (state_reg == S_UPD) begin
                t_reg <= t_reg + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            prod_re_reg <= s_data.pixel_col[USE_BITS-1:0] * step_re_reg;
            prod_im_reg <= s_data.pixel_row[USE_BITS-1:0] * step_im_reg;
        end
        if (state_reg == S_INIT) begin
            c_re_reg <= c_re_calc;
            c_im_reg <= c_im_calc;
            z_re_reg <= c_re_calc;
            z_im_reg <= c_im_calc;
        end else if (state_reg == S_UPD) begin
            z_re_reg <= nre;
            z_im_reg <= nim;
        end
        if (mul_done) begin
            if (state_reg == S_SQRE) sq_re_reg <= mul_prod;
            if (state_reg == S_SQIM) sq_im_reg <= mul_prod;
            if (state_reg == S_CROSS) cross_reg <= mul_prod;
        end
        if (out_load) begin
            out_reg.gray         <= in_set ? '0 : gray_val;
            out_reg.escape_count <= t_reg;
            out_reg.inside_set   <= in_set;
        end
    end

    mbet_mul #(
        .OP_BITS (MW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_prod)
    );

    mbet_gray u_gray (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (gray_start),
        .count   (t_reg),
        .limit   (max_iter_reg),
        .done    (gray_done),
        .gray    (gray_val)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // checks
    a_mul_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mul_busy)
        else $error("multiplier restarted while busy");

    a_mul_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == S_SQRE || state_reg == S_SQIM || state_reg == S_CROSS))
        else $error("multiplier result with no consumer");

    a_gray_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        gray_done |-> state_reg == S_GRAY)
        else $error("gray search finished outside its wait state");

    a_accept_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == S_INIT)
        else $error("accepted transaction did not start setup");

endmodule
`default_nettype wire

// File: sim/tb_mandelbrot_escape_time_pixel_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time_pixel_top: self-checking bench for the pixel unit
// Streams pixels through a series of view windows and iteration limits. A
// bit-exact fixed-point predictor kept here computes every result, and each
// output transaction is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_time_pixel_top;
    import mbet_pkg::*;

    localparam int COORD_BITS = 13;
    localparam int FRAC_BITS  = 28;
    localparam int ONE_Q      = 1 << FRAC_BITS;

    // escape when re^2 + im^2 > 4.0, compared at 2*FRAC_BITS fraction bits
    localparam logic signed [127:0] MAG_SQ_LIMIT = 128'sd4 <<< (2 * FRAC_BITS);
    localparam longint unsigned GRAY_TOP = 255;
    localparam longint unsigned GRAY_NUM = 260100;

    localparam int IDLE_PCT      = 27;
    localparam int QUIET_FROM    = 500;
    localparam int QUIET_TO      = 700;
    localparam int HOLD_AT       = 160;
    localparam int HOLD_CYCLES   = 3000;
    localparam int SETTLE_CYCLES = 32;
    localparam int DRAIN_CYCLES  = 64;
    localparam int MAX_PRINTED   = 40;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    mbet_in_t                  s_data    = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b0;
    mbet_out_t                 m_data;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

    // register image as the block should hold it
    logic signed [ORIGIN_BITS-1:0] view_origin_re = RST_ORIGIN_RE;
    logic signed [ORIGIN_BITS-1:0] view_origin_im = RST_ORIGIN_IM;
    logic [STEP_BITS-1:0]          view_step_re   = RST_STEP_RE;
    logic [STEP_BITS-1:0]          view_step_im   = RST_STEP_IM;
    logic [COUNT_BITS-1:0]         view_max_iter  = RST_MAX_ITER;

    mbet_in_t  pixel_backlog[$];
    mbet_out_t predicted_px[$];
    int        n_sent     = 0;
    int        n_recv     = 0;
    int        mismatches = 0;

    always #2 aclk = ~aclk;

    mandelbrot_escape_time_pixel_top #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    function automatic mbet_out_t escape_time_of(input mbet_in_t px);
        logic signed [63:0]  c_re, c_im, z_re, z_im;
        logic signed [127:0] w_re, w_im, sq_re, sq_im, xprod;
        logic [63:0]         offs;
        longint unsigned     lim, t, g, k, odd;
        bit                  escaped;
        mbet_out_t           res;
        c_re = view_origin_re;
        offs = 64'(px.pixel_col) * 64'(view_step_re);
        c_re = c_re + signed'(offs);
        c_im = view_origin_im;
        offs = 64'(px.pixel_row) * 64'(view_step_im);
        c_im = c_im + signed'(offs);
        lim = view_max_iter;
        escaped = 1'b0;
        z_re = c_re;
        z_im = c_im;
        for (t = 0; t < lim; t++) begin
            w_re = z_re;
            w_im = z_im;
            sq_re = w_re * w_re;
            sq_im = w_im * w_im;
            if (sq_re + sq_im > MAG_SQ_LIMIT) begin
                escaped = 1'b1;
                break;
            end
            xprod = (w_re * w_im) <<< 1;
            // both terms floored to FRAC_BITS before c is added
            z_re = 64'((sq_re - sq_im) >>> FRAC_BITS) + c_re;
            z_im = 64'(xprod >>> FRAC_BITS) + c_im;
        end
        g = 0;
        if (escaped) begin
            for (k = 1; k <= GRAY_TOP; k++) begin
                odd = 2 * k - 1;
                if (odd * odd * lim <= GRAY_NUM * t)
                    g = k;
                else
                    break;
            end
        end
        res.gray         = GRAY_BITS'(g);
        res.escape_count = COUNT_BITS'(t);
        res.inside_set   = !escaped;
        return res;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // called just after a rising edge; leaves the write enable high
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_ORIGIN_RE: view_origin_re = val;
            CFG_ORIGIN_IM: view_origin_im = val;
            CFG_STEP_RE:   view_step_re   = val[STEP_BITS-1:0];
            CFG_STEP_IM:   view_step_im   = val[STEP_BITS-1:0];
            CFG_MAX_ITER:  view_max_iter  = val[COUNT_BITS-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_view(input logic [CFG_DATA_BITS-1:0] o_re, input logic [CFG_DATA_BITS-1:0] o_im,
                            input logic [CFG_DATA_BITS-1:0] st_re, input logic [CFG_DATA_BITS-1:0] st_im,
                            input logic [CFG_DATA_BITS-1:0] lim);
        write_reg(CFG_ORIGIN_RE, o_re);
        write_reg(CFG_ORIGIN_IM, o_im);
        write_reg(CFG_STEP_RE, st_re);
        write_reg(CFG_STEP_IM, st_im);
        write_reg(CFG_MAX_ITER, lim);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_px(input int row, input int col);
        mbet_in_t px;
        px.pixel_row = PIX_BITS'(row);
        px.pixel_col = PIX_BITS'(col);
        pixel_backlog.push_back(px);
    endtask

    // sampled at the falling edge so every posedge update has landed
    task automatic settle();
        do @(negedge aclk);
        while (pixel_backlog.size() != 0 || s_valid || predicted_px.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : feed
        bit skip;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predicted_px.push_back(escape_time_of(s_data));
                n_sent++;
            end
            if (!s_valid || s_ready) begin
                skip = !(n_sent >= QUIET_FROM && n_sent < QUIET_TO) &&
                       ($urandom_range(99) < IDLE_PCT);
                if (pixel_backlog.size() != 0 && !skip) begin
                    s_valid <= 1'b1;
                    s_data  <= pixel_backlog.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : drain_ctl
        int hold_left = 0;
        bit hold_done = 1'b0;
        bit stall;
        if (aresetn) begin
            // one long back-pressure episode so the unit fills and blocks its input
            if (!hold_done && n_recv >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall = 1'b1;
            end else begin
                stall = !(n_recv >= QUIET_FROM && n_recv < QUIET_TO) &&
                        ($urandom_range(99) < IDLE_PCT);
            end
            m_ready <= !stall;
        end
    end

    always @(posedge aclk) begin : check
        mbet_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_px.size() == 0) begin
                flag_mismatch($sformatf("result %0d with nothing predicted: gray %0d count %0d inside %0b",
                                        n_recv, m_data.gray, m_data.escape_count, m_data.inside_set));
            end else begin
                want = predicted_px.pop_front();
                if (m_data.gray !== want.gray)
                    flag_mismatch($sformatf("result %0d gray %0d, want %0d",
                                            n_recv, m_data.gray, want.gray));
                if (m_data.escape_count !== want.escape_count)
                    flag_mismatch($sformatf("result %0d escape_count %0d, want %0d",
                                            n_recv, m_data.escape_count, want.escape_count));
                if (m_data.inside_set !== want.inside_set)
                    flag_mismatch($sformatf("result %0d inside_set %0b, want %0b",
                                            n_recv, m_data.inside_set, want.inside_set));
            end
            n_recv++;
        end
    end

    initial begin : stimulus
        int ph, i, k, n, kind, win, span, cre, cim;
        logic [CFG_DATA_BITS-1:0] lim;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset view: corner pixels, the origin of the plane, alternating bits
        queue_px(0, 0);
        queue_px(8191, 8191);
        queue_px(2400, 4200);
        queue_px(4095, 4095);
        queue_px(13'h1555, 13'h0AAA);
        queue_px(13'h0AAA, 13'h1555);
        settle();

        // writes to unused indexes must not disturb anything; zero iteration limit
        for (k = 1; k <= 3; k++)
            write_reg(3'(CFG_MAX_ITER) + 3'(k), $urandom);
        set_view(RST_ORIGIN_RE, RST_ORIGIN_IM, RST_STEP_RE, RST_STEP_IM, 0);
        queue_px(2400, 4200);
        queue_px(0, 0);
        settle();

        // extreme origins and steps (upper step bits are don't-care): huge c
        set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, ONE_Q, 4095);
        queue_px(0, 0);
        queue_px(8191, 8191);
        queue_px(8191, 0);
        queue_px(0, 8191);
        settle();

        // c = -1 with zero steps runs the full 4095 iterations
        set_view(-ONE_Q, 0, 0, 0, 4095);
        queue_px(8191, 8191);
        settle();

        // quarter steps from -2: hits |z|^2 == 4 exactly, limit of one
        set_view(-2 * ONE_Q, 0, ONE_Q >> 2, ONE_Q >> 2, 1);
        queue_px(0, 0);
        queue_px(0, 16);
        queue_px(0, 17);
        queue_px(0, 8);
        settle();

        set_view(-2 * ONE_Q, 0, ONE_Q >> 2, ONE_Q >> 2, 100);
        queue_px(0, 0);
        queue_px(0, 16);
        queue_px(0, 9);
        queue_px(0, 10);
        queue_px(4, 8);

        for (ph = 0; ph < 8; ph++) begin
            settle();
            if (ph == 0)
                lim = 1;
            else if (ph == 5)
                lim = $urandom_range(256, 400);
            else
                lim = $urandom_range(2, 100);
            n = (ph == 5) ? 40 : 160;
            kind = (ph == 0 || ph == 5) ? 0 : $urandom_range(9);
            if (kind <= 3) begin
                // whole set across the full coordinate range
                set_view(-603979776 + int'($urandom_range(0, 1 << 26)) - (1 << 25),
                         -402653184 + int'($urandom_range(0, 1 << 26)) - (1 << 25),
                         98304 + int'($urandom_range(0, 8192)) - 4096,
                         98304 + int'($urandom_range(0, 8192)) - 4096, lim);
                for (i = 0; i < n; i++)
                    queue_px($urandom_range(8191), $urandom_range(8191));
            end else if (kind <= 8) begin
                // small window somewhere near the set, a few stray pixels
                win  = $urandom_range(16, 512);
                k    = $urandom_range(16, 28);
                span = (1 << k) + int'($urandom_range(0, (1 << k) - 1));
                cre  = -2 * ONE_Q + int'($urandom_range(0, 671088640));
                cim  = -322122547 + int'($urandom_range(0, 644245094));
                set_view(cre - span / 2, cim - span / 2, span / win, span / win, lim);
                for (i = 0; i < n; i++) begin
                    if ($urandom_range(9) == 0)
                        queue_px($urandom_range(8191), $urandom_range(8191));
                    else
                        queue_px($urandom_range(win - 1), $urandom_range(win - 1));
                end
            end else begin
                set_view($urandom, $urandom, $urandom, $urandom, lim);
                for (i = 0; i < n; i++)
                    queue_px($urandom_range(8191), $urandom_range(8191));
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && predicted_px.size() == 0)
            $display("tb_mandelbrot_escape_time_pixel_top: done, clean");
        else
            $display("tb_mandelbrot_escape_time_pixel_top: done, errors");
        $finish;
    end

    initial begin : watchdog
        #40_000_000;
        $display("tb_mandelbrot_escape_time_pixel_top: done, errors");
        $finish;
    end

endmodule
`default_nettype wire

// File: files.f
rtl/mbet_pkg.sv
rtl/mbet_mul.sv
rtl/mbet_gray.sv
rtl/mandelbrot_escape_time_pixel_top.sv
sim/tb_mandelbrot_escape_time_pixel_top.sv
